@@ sv/eacf_pkg.sv @@
// Package for the edge-aware color fixup block: sizes, pixel and window types,
// opcodes, register indexes and the control word passed from the sequencer.
// No dependencies; all files but eacf_if and eacf_ram import it.
package eacf_pkg;

    // Largest row that the line buffers hold, and the edge magnitude width kept.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;
    localparam int EDGE_BITS  = 16;

    // Derived counter and address widths.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

    // Configuration port.
    localparam int W_REG_W    = 11;
    localparam int H_REG_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = H_REG_W;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // Item opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Window coordinates: rows from oldest line to newest, columns from newest pixel.
    localparam int WROW_TOP = 0;
    localparam int WROW_MID = 1;
    localparam int WROW_BOT = 2;
    localparam int WCOL_NEW = 0;
    localparam int WCOL_CTR = 1;
    localparam int WCOL_OLD = 2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        t_rgb                 c;
        logic [EDGE_BITS-1:0] e;
    } t_pix;

    localparam int PIX_W = $bits(t_pix);

    typedef t_pix [2:0][2:0] t_win;

    // Decision taken for an item when it is accepted.
    typedef struct packed {
        logic             pixel;
        logic             emit;
        logic             interior;
        logic             drain_win;
        logic             row_end;
        logic             frame_end;
        logic [COL_W-1:0] addr;
    } t_acc_info;

endpackage

@@ sv/eacf_if.sv @@
// Stream interfaces of the edge-aware color fixup block: pixel items in and
// corrected pixel items out, each with a valid/ready handshake. No dependencies.

interface eacf_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] edge_strength;

    modport source (output valid, output opcode, output red_in, output green_in,
                    output blue_in, output edge_strength, input ready);
    modport sink (input valid, input opcode, input red_in, input green_in,
                  input blue_in, input edge_strength, output ready);
endinterface

interface eacf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input row_end, input frame_end, output ready);
endinterface

@@ sv/eacf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered,
// read-first output that holds while the read enable is low. No dependencies.
module eacf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/eacf_seq.sv @@
// Accept-stage sequencer: configuration registers, write column, pending count
// and output position; decides for each item whether it releases a result.
// Depends on eacf_pkg.
module eacf_seq import eacf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic                  i_opcode,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_acc_info             o_info
);

    logic [WCNT_W-1:0] r_w, n_w;
    logic [HCNT_W-1:0] r_h, n_h;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;

    logic               is_pix;
    logic               in_col_last;
    logic               col_last;
    logic               row_last;
    logic               border;
    logic               pend_full;
    logic               emit;
    logic [PEND_W:0]    back_sub;
    logic [COL_W-1:0]   drain_addr;
    logic [W_REG_W-1:0] cfg_w;
    logic [H_REG_W-1:0] cfg_h;
    logic [WCNT_W-1:0]  clamp_w;
    logic [HCNT_W-1:0]  clamp_h;
    logic               restart;

    // Clamp written dimensions to the supported range.
    always_comb begin
        cfg_w = i_cfg_data[W_REG_W-1:0];
        cfg_h = i_cfg_data[H_REG_W-1:0];
        if (cfg_w < W_REG_W'(MIN_DIM)) begin
            clamp_w = WCNT_W'(MIN_DIM);
        end else if (cfg_w > W_REG_W'(MAX_WIDTH)) begin
            clamp_w = WCNT_W'(MAX_WIDTH);
        end else begin
            clamp_w = WCNT_W'(cfg_w);
        end
        if (cfg_h < H_REG_W'(MIN_DIM)) begin
            clamp_h = HCNT_W'(MIN_DIM);
        end else if (cfg_h > H_REG_W'(MAX_HEIGHT)) begin
            clamp_h = HCNT_W'(MAX_HEIGHT);
        end else begin
            clamp_h = HCNT_W'(cfg_h);
        end
    end

    // Position of the oldest pending pixel and the release decision.
    always_comb begin
        is_pix      = (i_opcode == OP_PIXEL);
        in_col_last = (WCNT_W'(r_in_col) == WCNT_W'(r_w - WCNT_W'(1)));
        col_last    = (WCNT_W'(r_out_col) == WCNT_W'(r_w - WCNT_W'(1)));
        row_last    = (HCNT_W'(r_out_row) == HCNT_W'(r_h - HCNT_W'(1)));
        border      = (r_out_row == '0) || row_last || (r_out_col == '0) || col_last;
        // A full row plus one pixel is waiting: the oldest one is the window center.
        pend_full   = (r_pend > PEND_W'(r_w));
        emit        = is_pix ? pend_full : ((r_pend != '0) && border);
        // Drain address: column of the oldest pending pixel in the line buffers.
        back_sub    = (PEND_W+1)'(r_in_col) - (PEND_W+1)'(r_pend);
        if (back_sub[PEND_W]) begin
            drain_addr = COL_W'(back_sub + (PEND_W+1)'(r_w));
        end else begin
            drain_addr = COL_W'(back_sub);
        end
        o_info.pixel     = is_pix;
        o_info.emit      = emit;
        o_info.interior  = !border;
        o_info.drain_win = pend_full;
        o_info.row_end   = col_last;
        o_info.frame_end = col_last && row_last;
        o_info.addr      = is_pix ? r_in_col : drain_addr;
    end

    // Next state: a register write restarts the stream, items advance the counters.
    always_comb begin
        n_w       = r_w;
        n_h       = r_h;
        n_in_col  = r_in_col;
        n_pend    = r_pend;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        restart   = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    n_w     = clamp_w;
                    restart = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    n_h     = clamp_h;
                    restart = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end else if (i_acc) begin
            if (is_pix) begin
                n_in_col = in_col_last ? '0 : COL_W'(r_in_col + 1'b1);
                n_pend   = emit ? r_pend : PEND_W'(r_pend + 1'b1);
            end else begin
                n_pend   = emit ? PEND_W'(r_pend - 1'b1) : r_pend;
            end
            if (emit) begin
                if (col_last) begin
                    n_out_col = '0;
                    n_out_row = row_last ? '0 : ROW_W'(r_out_row + 1'b1);
                end else begin
                    n_out_col = COL_W'(r_out_col + 1'b1);
                end
            end
        end
        if (restart) begin
            n_in_col  = '0;
            n_pend    = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WCNT_W'(640);
            r_h       <= HCNT_W'(480);
            r_in_col  <= '0;
            r_pend    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_in_col  <= n_in_col;
            r_pend    <= n_pend;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

@@ sv/eacf_window.sv @@
// 3x3 pixel window: three columns of registers that shift by one column per
// pixel item, fed by the new pixel and the two line buffer outputs.
// Depends on eacf_pkg.
module eacf_window import eacf_pkg::*; (
    input  logic i_clk,
    input  logic i_shift,
    input  t_pix i_top,
    input  t_pix i_mid,
    input  t_pix i_bot,
    output t_win o_win
);

    t_win r_win, n_win;

    // Shift older columns right and load the newest column.
    always_comb begin
        n_win = r_win;
        if (i_shift) begin
            for (int row = 0; row < 3; row++) begin
                n_win[row][WCOL_OLD] = r_win[row][WCOL_CTR];
                n_win[row][WCOL_CTR] = r_win[row][WCOL_NEW];
            end
            n_win[WROW_TOP][WCOL_NEW] = i_top;
            n_win[WROW_MID][WCOL_NEW] = i_mid;
            n_win[WROW_BOT][WCOL_NEW] = i_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_win = r_win;

endmodule

@@ sv/eacf_select.sv @@
// Correction logic for an interior window: finds the opposite-neighbor pair with
// the largest color distance, picks the endpoint nearer the center and replaces
// the center when its edge is stronger. Depends on eacf_pkg.
module eacf_select import eacf_pkg::*; (
    input  t_win i_win,
    output t_rgb o_rgb
);

    localparam int DIST_W = $clog2(3 * 255 + 1);

    // Directions in priority order.
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DNRT  = 2'd2;
    localparam logic [1:0] DIR_UPRT  = 2'd3;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? 8'(a - b) : 8'(b - a);
    endfunction

    function automatic logic [DIST_W-1:0] color_dist(input t_rgb a, input t_rgb b);
        return DIST_W'(abs_diff(a.r, b.r)) + DIST_W'(abs_diff(a.g, b.g))
             + DIST_W'(abs_diff(a.b, b.b));
    endfunction

    t_pix              ctr;
    t_pix              end_a [4];
    t_pix              end_b [4];
    t_pix              pick  [4];
    logic [DIST_W-1:0] pair_d [4];
    logic              repl  [4];
    logic [1:0]        win01;
    logic [1:0]        win23;
    logic [1:0]        best;

    // Endpoints of each direction around the center.
    always_comb begin
        ctr              = i_win[WROW_MID][WCOL_CTR];
        end_a[DIR_DOWN]  = i_win[WROW_BOT][WCOL_CTR];
        end_b[DIR_DOWN]  = i_win[WROW_TOP][WCOL_CTR];
        end_a[DIR_RIGHT] = i_win[WROW_MID][WCOL_NEW];
        end_b[DIR_RIGHT] = i_win[WROW_MID][WCOL_OLD];
        end_a[DIR_DNRT]  = i_win[WROW_BOT][WCOL_NEW];
        end_b[DIR_DNRT]  = i_win[WROW_TOP][WCOL_OLD];
        end_a[DIR_UPRT]  = i_win[WROW_TOP][WCOL_NEW];
        end_b[DIR_UPRT]  = i_win[WROW_BOT][WCOL_OLD];
    end

    // Per-direction distances, nearer endpoint and replace decision, in parallel.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pair_d[k] = color_dist(end_a[k].c, end_b[k].c);
            pick[k]   = (color_dist(end_a[k].c, ctr.c) <= color_dist(end_b[k].c, ctr.c))
                      ? end_a[k] : end_b[k];
            repl[k]   = (ctr.e > pick[k].e);
        end
    end

    // Two-level maximum; the earlier direction wins ties at each level.
    always_comb begin
        win01 = (pair_d[DIR_RIGHT] > pair_d[DIR_DOWN]) ? DIR_RIGHT : DIR_DOWN;
        win23 = (pair_d[DIR_UPRT] > pair_d[DIR_DNRT]) ? DIR_UPRT : DIR_DNRT;
        best  = (pair_d[win23] > pair_d[win01]) ? win23 : win01;
        o_rgb = repl[best] ? pick[best].c : ctr.c;
    end

endmodule

@@ sv/edge_aware_color_fixup_top.sv @@
// Top level of the edge-aware color fixup block: line buffers, window, pipeline
// handshake and result register. Depends on eacf_pkg, eacf_if, eacf_ram,
// eacf_seq, eacf_window and eacf_select.
//
// The block takes one item per clock while ready is high and gives corrected
// pixels in raster order, one row plus one pixel behind the input: a pixel item
// releases the pixel w+1 positions earlier, and its result passes through three
// register stages (input stage with line buffer reads, window stage, result
// register). Two 1024 x 40 line buffers, each with one write and one registered
// read port, feed the 3x3 window; they need no clearing after reset. Drain items
// release only border pixels at the tail of a frame, one per item, and take the
// pending pixel from the newest line buffer, or from the window while a full row
// plus one pixel is pending. A width or height register write restarts the stream
// and drops pending pixels. Ready drops only when all three stages hold items and
// the result is not taken.
module edge_aware_color_fixup_top import eacf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    eacf_in_if.sink               i_pix,
    eacf_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_acc_info        acc_info;
    logic             in_acc;
    t_pix             in_pix;
    logic [PIX_W-1:0] lba_q;
    logic [PIX_W-1:0] lbb_q;
    t_pix             lba_pix;
    t_pix             lbb_pix;
    t_win             win;
    t_rgb             fix_rgb;
    logic             s1_go;
    logic             s2_go;
    t_rgb             s2_rgb;

    // Input stage registers.
    logic      r_s1_vld;
    t_acc_info r_s1_info;
    t_pix      r_s1_pix;

    // Window stage registers.
    logic r_s2_vld;
    logic r_s2_interior;
    logic r_s2_drain;
    t_rgb r_s2_dcol;
    logic r_s2_row_end;
    logic r_s2_frame_end;

    // Result register.
    logic r_o_vld;
    t_rgb r_o_rgb;
    logic r_o_row_end;
    logic r_o_frame_end;

    // Handshake: each stage moves when the one after it is empty or moving.
    assign s2_go       = r_s2_vld && (!r_o_vld || o_res.ready);
    assign s1_go       = r_s1_vld && (!r_s2_vld || s2_go);
    assign i_pix.ready = !r_s1_vld || s1_go;
    assign in_acc      = i_pix.valid && i_pix.ready;

    always_comb begin
        in_pix.c.r = i_pix.red_in;
        in_pix.c.g = i_pix.green_in;
        in_pix.c.b = i_pix.blue_in;
        in_pix.e   = i_pix.edge_strength[EDGE_BITS-1:0];
    end

    eacf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_opcode   (i_pix.opcode),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_info     (acc_info)
    );

    // Newest line buffer: written with each pixel, read one row back (or at the
    // pending pixel for a drain item).
    eacf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lb_a (
        .i_clk   (i_clk),
        .i_we    (in_acc && acc_info.pixel),
        .i_waddr (acc_info.addr),
        .i_wdata (in_pix),
        .i_re    (in_acc),
        .i_raddr (acc_info.addr),
        .o_rdata (lba_q)
    );

    // Older line buffer: takes what leaves the newest one, read two rows back.
    eacf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lb_b (
        .i_clk   (i_clk),
        .i_we    (r_s1_vld && r_s1_info.pixel),
        .i_waddr (r_s1_info.addr),
        .i_wdata (lba_q),
        .i_re    (in_acc && acc_info.pixel),
        .i_raddr (acc_info.addr),
        .o_rdata (lbb_q)
    );

    assign lba_pix = lba_q;
    assign lbb_pix = lbb_q;

    eacf_window u_window (
        .i_clk   (i_clk),
        .i_shift (s1_go && r_s1_info.pixel),
        .i_top   (lbb_pix),
        .i_mid   (lba_pix),
        .i_bot   (r_s1_pix),
        .o_win   (win)
    );

    eacf_select u_select (
        .i_win (win),
        .o_rgb (fix_rgb)
    );

    // Result color: drained pixel, corrected interior pixel or unchanged border.
    always_comb begin
        if (r_s2_drain) begin
            s2_rgb = r_s2_dcol;
        end else if (r_s2_interior) begin
            s2_rgb = fix_rgb;
        end else begin
            s2_rgb = win[WROW_MID][WCOL_CTR].c;
        end
    end

    // Stage valid flags; only items that release a result occupy the window stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_s2_vld <= r_s1_info.emit;
            end else if (s2_go) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_go) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_info <= acc_info;
            r_s1_pix  <= in_pix;
        end
        if (s1_go) begin
            r_s2_interior  <= r_s1_info.pixel && r_s1_info.interior;
            r_s2_drain     <= !r_s1_info.pixel;
            r_s2_dcol      <= r_s1_info.drain_win ? win[WROW_MID][WCOL_NEW].c : lba_pix.c;
            r_s2_row_end   <= r_s1_info.row_end;
            r_s2_frame_end <= r_s1_info.frame_end;
        end
        if (s2_go) begin
            r_o_rgb       <= s2_rgb;
            r_o_row_end   <= r_s2_row_end;
            r_o_frame_end <= r_s2_frame_end;
        end
    end

    assign o_res.valid     = r_o_vld;
    assign o_res.red_out   = r_o_rgb.r;
    assign o_res.green_out = r_o_rgb.g;
    assign o_res.blue_out  = r_o_rgb.b;
    assign o_res.row_end   = r_o_row_end;
    assign o_res.frame_end = r_o_frame_end;

    // An accepted item always lands in the input stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) in_acc |=> r_s1_vld)
        else $error("accepted item did not reach the input stage");

    // Input back-pressure only when every stage is occupied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_s1_vld && r_s2_vld && r_o_vld))
        else $error("input stalled while the pipeline has room");

    // Drain items release border pixels only.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_drain) |-> !r_s2_interior)
        else $error("drain item released an interior pixel");

    // The last pixel of a frame is also the last of its row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_frame_end) |-> r_o_row_end)
        else $error("frame end without row end");

endmodule

@@ test/edge_aware_color_fixup_checker.sv @@
// Checker for the edge-aware color fixup block: watches both item channels and the
// register port, predicts every corrected pixel and compares it with the block.
// Depends on eacf_pkg and the interfaces in eacf_if.
`timescale 1ns / 100ps

module edge_aware_color_fixup_checker import eacf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    eacf_in_if                    i_pix,
    eacf_out_if                   i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_expected_count
);

    // Pixel history: two rows plus a few pixels always fit without wrapping onto
    // entries that are still needed.
    localparam int HISTORY_LEN  = 2 * MAX_WIDTH + 4;
    localparam int REPORT_LIMIT = 40;

    // Neighbor pairs, tried in this order; the first one wins a tie.
    typedef enum int {DIR_DOWN, DIR_RIGHT, DIR_DOWN_RIGHT, DIR_UP_RIGHT} t_dir;

    typedef struct packed {
        t_rgb rgb;
        logic row_end;
        logic frame_end;
    } t_fixed_pix;

    t_pix               history [HISTORY_LEN];
    t_fixed_pix         expected_pixels [$];
    int unsigned        wr_ptr;
    int unsigned        pending_cnt;
    int unsigned        out_col;
    int unsigned        out_row;
    logic [W_REG_W-1:0] width_reg;
    logic [H_REG_W-1:0] height_reg;

    function automatic int unsigned used_width();
        if (width_reg < MIN_DIM) return MIN_DIM;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg < MIN_DIM) return MIN_DIM;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic int unsigned chan_diff(logic [7:0] a, logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Manhattan distance between two colors.
    function automatic int unsigned rgb_dist(t_rgb a, t_rgb b);
        return chan_diff(a.r, b.r) + chan_diff(a.g, b.g) + chan_diff(a.b, b.b);
    endfunction

    function automatic int unsigned ring_index(int unsigned pos, int off);
        return (int'(pos) + HISTORY_LEN + off) % HISTORY_LEN;
    endfunction

    // Distance in the history from the center to the "plus" end of a pair.
    function automatic int step_offset(t_dir d, int w);
        case (d)
            DIR_DOWN:       return w;
            DIR_RIGHT:      return 1;
            DIR_DOWN_RIGHT: return w + 1;
            DIR_UP_RIGHT:   return 1 - w;
            default:        return 0;
        endcase
    endfunction

    function automatic bit at_border();
        return out_row == 0 || out_row == used_height() - 1 ||
               out_col == 0 || out_col == used_width() - 1;
    endfunction

    function automatic void restart_stream();
        wr_ptr      = 0;
        pending_cnt = 0;
        out_col     = 0;
        out_row     = 0;
    endfunction

    // Corrects the oldest pending pixel, retires it and advances the output position.
    function automatic t_fixed_pix release_oldest();
        int unsigned w;
        int unsigned h;
        int unsigned cpos;
        int unsigned pair_dist;
        int          best_dist;
        int          best_off;
        int          off;
        int          k;
        t_pix        ctr;
        t_pix        plus_end;
        t_pix        minus_end;
        t_pix        pick;
        t_fixed_pix  fixed;

        w     = used_width();
        h     = used_height();
        cpos  = (wr_ptr + HISTORY_LEN - pending_cnt) % HISTORY_LEN;
        ctr   = history[cpos];
        fixed = '0;
        fixed.rgb = ctr.c;
        if (!at_border()) begin
            best_dist = -1;
            best_off  = 0;
            for (k = 0; k < 4; k++) begin
                off       = step_offset(t_dir'(k), w);
                pair_dist = rgb_dist(history[ring_index(cpos, off)].c,
                                     history[ring_index(cpos, -off)].c);
                if (int'(pair_dist) > best_dist) begin
                    best_dist = pair_dist;
                    best_off  = off;
                end
            end
            plus_end  = history[ring_index(cpos, best_off)];
            minus_end = history[ring_index(cpos, -best_off)];
            pick = (rgb_dist(plus_end.c, ctr.c) <= rgb_dist(minus_end.c, ctr.c)) ?
                   plus_end : minus_end;
            if (ctr.e > pick.e) fixed.rgb = pick.c;
        end
        fixed.row_end   = (out_col == w - 1);
        fixed.frame_end = (out_col == w - 1) && (out_row == h - 1);
        pending_cnt--;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
        return fixed;
    endfunction

    // A pixel item may push out the pixel one row plus one behind it; a drain item
    // releases the oldest pending pixel only when it lies on the border.
    task automatic take_item(logic op, t_pix p);
        if (op == OP_PIXEL) begin
            history[wr_ptr] = p;
            wr_ptr = (wr_ptr + 1) % HISTORY_LEN;
            pending_cnt++;
            if (pending_cnt > used_width() + 1) expected_pixels.push_back(release_oldest());
        end else if (pending_cnt != 0 && at_border()) begin
            expected_pixels.push_back(release_oldest());
        end
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (o_fail_count < REPORT_LIMIT)
            $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_result();
        t_fixed_pix want;

        if (expected_pixels.size() == 0) begin
            report_mismatch("result item with nothing expected (rgb)",
                            {i_res.red_out, i_res.green_out, i_res.blue_out}, 0);
            return;
        end
        want = expected_pixels.pop_front();
        if (i_res.red_out !== want.rgb.r)
            report_mismatch("red_out", i_res.red_out, want.rgb.r);
        if (i_res.green_out !== want.rgb.g)
            report_mismatch("green_out", i_res.green_out, want.rgb.g);
        if (i_res.blue_out !== want.rgb.b)
            report_mismatch("blue_out", i_res.blue_out, want.rgb.b);
        if (i_res.row_end !== want.row_end)
            report_mismatch("row_end", i_res.row_end, want.row_end);
        if (i_res.frame_end !== want.frame_end)
            report_mismatch("frame_end", i_res.frame_end, want.frame_end);
    endtask

    // Results are checked before the input of the same edge is taken; an input item
    // cannot show up at the output in the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = W_REG_W'(640);
            height_reg = H_REG_W'(480);
            restart_stream();
            expected_pixels.delete();
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) check_result();
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[W_REG_W-1:0];
                        restart_stream();
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[H_REG_W-1:0];
                        restart_stream();
                    end
                    default: ;
                endcase
            end
            if (i_pix.valid === 1'b1 && i_pix.ready === 1'b1)
                take_item(i_pix.opcode,
                          '{c: '{r: i_pix.red_in, g: i_pix.green_in, b: i_pix.blue_in},
                            e: i_pix.edge_strength});
        end
        o_expected_count = expected_pixels.size();
    end

endmodule

@@ test/edge_aware_color_fixup_top_tb.sv @@
// Testbench top for the edge-aware color fixup block: clock, reset, register writes,
// pixel and drain stimulus with bursts and output stalls, and the verdict.
// Depends on eacf_pkg, eacf_if, the block's RTL and edge_aware_color_fixup_checker.
`timescale 1ns / 100ps

module edge_aware_color_fixup_top_tb;
    import eacf_pkg::*;

    localparam int  RANDOM_ITEMS     = 1700;
    localparam int  SETTLE_CYCLES    = 10;
    localparam int  LONG_HOLD_CYCLES = 400;
    localparam time RUN_LIMIT        = 18_000_000;

    // Indexes that address no register; writes there must not restart the stream.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum int {PH_SMALL, PH_WIDE, PH_TALL} t_phase_kind;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [CFG_DATA_W-1:0] width_data;
    logic [CFG_DATA_W-1:0] height_data;
    int                    fail_count;
    int                    expected_count;
    int                    burst_left;
    int                    sent_items;
    int                    phase_no;
    int                    hold_requests;
    int                    holds_served;
    int                    hold_left;
    int                    mode_left;
    int                    rx_cycle;
    t_rx_mode              rx_mode;
    logic                  ready_next;

    eacf_in_if  pix_if();
    eacf_out_if res_if();

    edge_aware_color_fixup_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    edge_aware_color_fixup_checker u_fixup_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pix            (pix_if),
        .i_res            (res_if),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_expected_count (expected_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("edge_aware_color_fixup_top_tb failed");
        $finish;
    end

    // Output side: stalls in changing modes, plus a long hold-off on request.
    initial begin
        res_if.ready = 1'b0;
        hold_left    = 0;
        mode_left    = 0;
        holds_served = 0;
        rx_cycle     = 0;
        rx_mode      = RX_FREE;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:     ready_next = 1'b1;
                    RX_LIGHT:    ready_next = ($urandom_range(0, 3) != 0);
                    RX_HEAVY:    ready_next = ($urandom_range(0, 3) == 0);
                    default:     ready_next = (rx_cycle % 5) < 3;
                endcase
            end
            res_if.ready <= ready_next;
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // Coarse colors come from three levels so that distances tie often.
    function automatic logic [7:0] pick_level(bit coarse);
        if (coarse) return 8'(($urandom_range(0, 2) * 255 + 1) / 2);
        return 8'($urandom);
    endfunction

    function automatic t_pix random_pixel(bit coarse);
        t_pix p;

        p.c.r = pick_level(coarse);
        p.c.g = pick_level(coarse);
        p.c.b = pick_level(coarse);
        case ($urandom_range(0, 3))
            0:       p.e = '0;
            1:       p.e = '1;
            2:       p.e = EDGE_BITS'($urandom_range(0, 3));
            default: p.e = EDGE_BITS'($urandom);
        endcase
        return p;
    endfunction

    // Directed 3x3 frames. The first has extreme colors and equal edge strengths, so
    // the center stays. In the second every pair is equally far apart and both ends
    // are equally near the center, so the lower end of the vertical pair wins.
    function automatic t_pix directed_pixel(int frame_no, int idx);
        t_pix p;

        if (frame_no == 0) begin
            p.c.r = idx[0] ? 8'hFF : 8'h00;
            p.c.g = idx[1] ? 8'hFF : 8'h00;
            p.c.b = idx[2] ? 8'hFF : 8'h00;
            p.e   = '1;
            if (idx == 4) p.c = '{r: 8'd128, g: 8'd128, b: 8'd128};
        end else begin
            p.e = '0;
            case (idx)
                2, 7:    p.c = '{r: 8'd10, g: 8'd0, b: 8'd0};
                5:       p.c = '{r: 8'd0, g: 8'd10, b: 8'd0};
                8:       p.c = '{r: 8'd0, g: 8'd0, b: 8'd10};
                4: begin
                    p.c = '{r: 8'd5, g: 8'd5, b: 8'd5};
                    p.e = '1;
                end
                default: p.c = '0;
            endcase
        end
        return p;
    endfunction

    // Offers one item and returns at the falling edge after it was accepted.
    task automatic send_item(logic op, t_pix p);
        if (burst_left == 0) begin
            if (pix_if.valid) pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        pix_if.valid         <= 1'b1;
        pix_if.opcode        <= op;
        pix_if.red_in        <= p.c.r;
        pix_if.green_in      <= p.c.g;
        pix_if.blue_in       <= p.c.b;
        pix_if.edge_strength <= p.e;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_drain();
        send_item(OP_DRAIN, random_pixel(1'b0));
    endtask

    // Stops offering and waits until every predicted pixel has come out.
    task automatic wait_for_results(bit with_tail);
        if (pix_if.valid) pix_if.valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (expected_count != 0) @(negedge i_clk);
        if (with_tail) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        if (idx == REG_IMAGE_WIDTH) width_data = value;
        if (idx == REG_IMAGE_HEIGHT) height_data = value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // One setting of the registers followed by a stream of frames: mostly complete
    // frames and their drain ticks, with stray drains and cut-off frames mixed in.
    task automatic run_phase(t_phase_kind kind, bit force_hold, bit force_pause);
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;
        int                    w;
        int                    h;
        int                    frames;
        int                    n_px;
        int                    n_drains;
        int                    hold_at;
        int                    pause_at;
        int                    px_cnt;
        int                    i;
        bit                    coarse;

        wait_for_results(1'b1);
        case (kind)
            PH_WIDE: begin
                // Either a width above the largest row, or a wide row that still
                // fits two full rows into the item budget.
                if ($urandom_range(0, 1)) begin
                    wdata = '1;
                end else begin
                    wdata = CFG_DATA_W'($urandom_range(100, 300));
                end
                hdata = '0;
            end
            PH_TALL: begin
                wdata = CFG_DATA_W'($urandom_range(3, 6));
                hdata = '1;
            end
            default: begin
                case ($urandom_range(0, 9))
                    0:       wdata = CFG_DATA_W'($urandom_range(0, 2));
                    1:       wdata = {2'($urandom_range(1, 3)), 11'($urandom_range(3, 12))};
                    default: wdata = CFG_DATA_W'($urandom_range(3, 12));
                endcase
                case ($urandom_range(0, 9))
                    0:       hdata = CFG_DATA_W'($urandom_range(0, 2));
                    1:       hdata = CFG_DATA_W'(MAX_HEIGHT);
                    default: hdata = CFG_DATA_W'($urandom_range(3, 8));
                endcase
            end
        endcase

        // Usually both registers, in either order; sometimes only one of them.
        if (kind != PH_SMALL || $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1)) begin
                write_register(REG_IMAGE_WIDTH, wdata);
                write_register(REG_IMAGE_HEIGHT, hdata);
            end else begin
                write_register(REG_IMAGE_HEIGHT, hdata);
                write_register(REG_IMAGE_WIDTH, wdata);
            end
        end else if ($urandom_range(0, 1)) begin
            write_register(REG_IMAGE_WIDTH, wdata);
        end else begin
            write_register(REG_IMAGE_HEIGHT, hdata);
        end
        if ($urandom_range(0, 5) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                           CFG_DATA_W'($urandom));

        w        = clamp_dim(width_data[W_REG_W-1:0], MAX_WIDTH);
        h        = clamp_dim(height_data[H_REG_W-1:0], MAX_HEIGHT);
        coarse   = ($urandom_range(0, 2) == 0);
        frames   = (kind == PH_SMALL) ? $urandom_range(1, 3) : 1;
        // A forced hold starts before the first pixel so that the block backs up.
        if (force_hold)
            hold_at = 0;
        else
            hold_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * w) : -1;
        pause_at = (force_pause || $urandom_range(0, 5) == 0) ? $urandom_range(0, 2 * w) : -1;
        px_cnt   = 0;

        repeat (frames) begin
            n_px = w * h;
            if (kind == PH_WIDE)
                n_px = (w == MAX_WIDTH) ? $urandom_range(200, 400) : 2 * w + 4;
            else if (force_hold && px_cnt == 0)
                n_px = 3 * w + 5;
            else if (n_px > 400 || $urandom_range(0, 7) == 0)
                n_px = $urandom_range(1, 3 * w + 5);
            for (i = 0; i < n_px; i++) begin
                if ($urandom_range(0, 24) == 0) send_drain();
                if (px_cnt == hold_at) hold_requests++;
                if (px_cnt == pause_at) wait_for_results(1'b0);
                send_item(OP_PIXEL, random_pixel(coarse));
                px_cnt++;
            end
            // Flush the tail, or let the next frame push it out.
            if ($urandom_range(0, 9) < 7) begin
                if (kind == PH_WIDE && n_px < w)
                    n_drains = n_px + 1 + $urandom_range(0, 2);
                else
                    n_drains = w + 1 + $urandom_range(0, 2);
                repeat (n_drains) send_drain();
            end
        end
    endtask

    // Main stimulus.
    initial begin
        int i;

        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        pix_if.valid         = 1'b0;
        pix_if.opcode        = OP_PIXEL;
        pix_if.red_in        = '0;
        pix_if.green_in      = '0;
        pix_if.blue_in       = '0;
        pix_if.edge_strength = '0;
        width_data           = CFG_DATA_W'(640);
        height_data          = CFG_DATA_W'(480);
        burst_left           = 0;
        sent_items           = 0;
        hold_requests        = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: a 3x3 image (width below the minimum is raised to it).
        write_register(REG_IMAGE_WIDTH, '0);
        write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        send_drain();
        for (i = 0; i < 8; i++) send_item(OP_PIXEL, directed_pixel(0, i));
        // The oldest pending pixel is the interior one, so this drain gives nothing.
        send_drain();
        send_item(OP_PIXEL, directed_pixel(0, 8));
        // The second frame pushes out the border tail of the first.
        for (i = 0; i < 9; i++) send_item(OP_PIXEL, directed_pixel(1, i));
        repeat (5) send_drain();

        // Random part; the wide and tall settings come once each.
        phase_no = 0;
        while (sent_items < RANDOM_ITEMS || phase_no < 5) begin
            case (phase_no)
                2:       run_phase(PH_WIDE, 1'b0, 1'b0);
                4:       run_phase(PH_TALL, 1'b0, 1'b0);
                default: run_phase(PH_SMALL, phase_no == 0, phase_no == 1);
            endcase
            phase_no++;
        end

        wait_for_results(1'b1);
        if (fail_count == 0) begin
            $display("edge_aware_color_fixup_top_tb passed");
        end else begin
            $display("edge_aware_color_fixup_top_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/eacf_pkg.sv
sv/eacf_if.sv
sv/eacf_ram.sv
sv/eacf_seq.sv
sv/eacf_window.sv
sv/eacf_select.sv
sv/edge_aware_color_fixup_top.sv
test/edge_aware_color_fixup_checker.sv
test/edge_aware_color_fixup_top_tb.sv
